// File: hw/rtl/llre_pkg.sv
// Shared types, codes and sizes of the linked list reorder engine.
`timescale 1ns / 1ps

package llre_pkg;

   // Largest list the link memories hold, plus the head sentinel at entry 0
   localparam int MAX_ENTRIES = 1024;
   localparam int LINK_DEPTH  = MAX_ENTRIES + 1;

   // Field widths of the item channels
   localparam int ENTRY_W = 11;
   localparam int MODE_W  = 3;
   localparam int SUM_W   = 20;

   // Item modes
   localparam logic [MODE_W-1:0] MODE_INIT    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_BEFORE  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_AFTER   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SWAP    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_REVERSE = 3'd4;
   localparam logic [MODE_W-1:0] MODE_REPORT  = 3'd5;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_Y,
      ST_RD_X,
      ST_PLAN,
      ST_JOIN,
      ST_INIT,
      ST_HEAD,
      ST_WALK,
      ST_FIX,
      ST_OUT
   } state_type;

   // Shared adder operations
   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type       op;
      logic [SUM_W-1:0] a;
      logic [SUM_W-1:0] b;
   } alu_req_type;

   // One write into a link memory
   typedef struct packed {
      logic               en;
      logic [ENTRY_W-1:0] addr;
      logic [ENTRY_W-1:0] data;
   } ram_wr_type;

endpackage

// File: hw/rtl/llre_ram.sv
// Generic single write, single read RAM with registered read data.
`timescale 1ns / 1ps

module llre_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port; drop writes past the last entry
   always_ff @(posedge clock) begin
      if (wr_en && (32'(wr_addr) < 32'(DEPTH))) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/llre_alu.sv
// Shared add and subtract unit used by init, report walk and complement.
`timescale 1ns / 1ps

module llre_alu
   import llre_pkg::*;
(
   input  alu_req_type      alu_req,
   output logic [SUM_W-1:0] alu_res
);

   // One adder, both senses, modulo 2^SUM_W
   always_comb begin
      case (alu_req.op)
         ALU_ADD: alu_res = alu_req.a + alu_req.b;
         ALU_SUB: alu_res = alu_req.a - alu_req.b;
         default: alu_res = alu_req.a;
      endcase
   end

endmodule

// File: hw/rtl/llre_seq.sv
// Sequencer of the reorder engine: link reads, rejoins, init sweep and report walk.
`timescale 1ns / 1ps

module llre_seq
   import llre_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [ENTRY_W-1:0] count,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [MODE_W-1:0]  req_mode,
   input  logic [ENTRY_W-1:0] req_entry_a,
   input  logic [ENTRY_W-1:0] req_entry_b,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [SUM_W-1:0]   rsp_odd_position_sum,
   output logic [ENTRY_W-1:0] rd_addr,
   input  logic [ENTRY_W-1:0] next_rdata,
   input  logic [ENTRY_W-1:0] prev_rdata,
   output ram_wr_type         next_wr,
   output ram_wr_type         prev_wr,
   output alu_req_type        alu_req,
   input  logic [SUM_W-1:0]   alu_res
);

   state_type          state_ff, state_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [ENTRY_W-1:0] xa_ff, xa_in, xb_ff, xb_in;
   logic [ENTRY_W-1:0] px_ff, px_in, nx_ff, nx_in;
   logic [ENTRY_W-1:0] py_ff, py_in, ny_ff, ny_in;
   logic [ENTRY_W-1:0] cnt_ff, cnt_in;
   logic [ENTRY_W-1:0] lag_ff, lag_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [SUM_W-1:0]   total_ff, total_in;
   logic               flag_ff, flag_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]   rsp_data_ff, rsp_data_in;

   logic               accept;
   logic               bad_entries;
   logic               adjacent;
   logic [1:0]         last_step;
   logic [ENTRY_W-1:0] join_l, join_r;
   logic [22:0]        prod;

   assign req_stall            = (state_ff != ST_IDLE);
   assign accept               = req_valid && !req_stall;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_odd_position_sum = rsp_data_ff;

   // Entries must lie in 1..n and differ
   assign bad_entries = (req_entry_a == '0) || (req_entry_b == '0) ||
                        (req_entry_a > count) || (req_entry_b > count) ||
                        (req_entry_a == req_entry_b);

   // n(n+1), halved where used, for the reversed-list complement
   assign prod = 23'(count) * (23'(count) + 23'd1);

   // Rejoin plan: x right before y means a swap only exchanges the two
   assign adjacent  = (nx_ff == xb_ff);
   assign last_step = ((mode_ff != MODE_SWAP) || adjacent) ? 2'd2 : 2'd3;

   always_comb begin
      join_l = px_ff;
      join_r = nx_ff;
      case (mode_ff)
         MODE_BEFORE: begin
            case (cnt_ff[1:0])
               2'd0:    begin join_l = px_ff; join_r = nx_ff; end
               2'd1:    begin join_l = py_ff; join_r = xa_ff; end
               default: begin join_l = xa_ff; join_r = xb_ff; end
            endcase
         end
         MODE_AFTER: begin
            case (cnt_ff[1:0])
               2'd0:    begin join_l = px_ff; join_r = nx_ff; end
               2'd1:    begin join_l = xa_ff; join_r = ny_ff; end
               default: begin join_l = xb_ff; join_r = xa_ff; end
            endcase
         end
         default: begin
            if (adjacent) begin
               case (cnt_ff[1:0])
                  2'd0:    begin join_l = px_ff; join_r = xb_ff; end
                  2'd1:    begin join_l = xb_ff; join_r = xa_ff; end
                  default: begin join_l = xa_ff; join_r = ny_ff; end
               endcase
            end else begin
               case (cnt_ff[1:0])
                  2'd0:    begin join_l = px_ff; join_r = xb_ff; end
                  2'd1:    begin join_l = xb_ff; join_r = nx_ff; end
                  2'd2:    begin join_l = py_ff; join_r = xa_ff; end
                  default: begin join_l = xa_ff; join_r = ny_ff; end
               endcase
            end
         end
      endcase
   end

   // Next state and outputs
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      xa_in        = xa_ff;
      xb_in        = xb_ff;
      px_in        = px_ff;
      nx_in        = nx_ff;
      py_in        = py_ff;
      ny_in        = ny_ff;
      cnt_in       = cnt_ff;
      lag_in       = lag_ff;
      sum_in       = sum_ff;
      total_in     = total_ff;
      flag_in      = flag_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = '0;
      next_wr      = '0;
      prev_wr      = '0;
      alu_req      = '{op: ALU_ADD, a: sum_ff, b: '0};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in = req_mode;
               xa_in   = req_entry_a;
               xb_in   = req_entry_b;
               case (req_mode)
                  MODE_INIT: begin
                     cnt_in   = ENTRY_W'(1);
                     lag_in   = '0;
                     flag_in  = 1'b0;
                     state_in = ST_INIT;
                  end
                  MODE_BEFORE, MODE_AFTER, MODE_SWAP: begin
                     // Fetch the links of y first
                     rd_addr = req_entry_b;
                     if (!bad_entries) begin
                        state_in = ST_RD_Y;
                     end
                  end
                  MODE_REVERSE: begin
                     flag_in = !flag_ff;
                  end
                  MODE_REPORT: begin
                     // Start the walk at the sentinel
                     rd_addr  = '0;
                     cnt_in   = ENTRY_W'(1);
                     sum_in   = '0;
                     total_in = prod[SUM_W:1];
                     state_in = ST_WALK;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_RD_Y: begin
            ny_in    = next_rdata;
            py_in    = prev_rdata;
            rd_addr  = xa_ff;
            state_in = ST_RD_X;
         end

         ST_RD_X: begin
            nx_in    = next_rdata;
            px_in    = prev_rdata;
            state_in = ST_PLAN;
         end

         ST_PLAN: begin
            cnt_in   = '0;
            state_in = ST_JOIN;
            if (mode_ff == MODE_SWAP) begin
               // y right before x: exchange roles so that x leads
               if (ny_ff == xa_ff) begin
                  xa_in = xb_ff;
                  xb_in = xa_ff;
                  nx_in = ny_ff;
                  ny_in = nx_ff;
                  px_in = py_ff;
                  py_in = px_ff;
               end
            end else begin
               // Reversed list turns before into after and back
               if (flag_ff) begin
                  mode_in = (mode_ff == MODE_BEFORE) ? MODE_AFTER : MODE_BEFORE;
               end
               // Drop moves that leave the order as it is
               if (((mode_in == MODE_BEFORE) && (xa_ff == py_ff)) ||
                   ((mode_in == MODE_AFTER) && (xa_ff == ny_ff))) begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_JOIN: begin
            next_wr = '{en: 1'b1, addr: join_l, data: join_r};
            prev_wr = '{en: 1'b1, addr: join_r, data: join_l};
            cnt_in  = cnt_ff + ENTRY_W'(1);
            if (cnt_ff[1:0] == last_step) begin
               state_in = ST_IDLE;
            end
         end

         ST_INIT: begin
            // Link entry i between i-1 and i+1, the last one back to the sentinel
            alu_req = '{op: ALU_ADD, a: SUM_W'(cnt_ff), b: SUM_W'(1)};
            next_wr = '{en: 1'b1, addr: cnt_ff,
                        data: (cnt_ff == count) ? '0 : alu_res[ENTRY_W-1:0]};
            prev_wr = '{en: 1'b1, addr: cnt_ff, data: lag_ff};
            lag_in  = cnt_ff;
            cnt_in  = alu_res[ENTRY_W-1:0];
            if (cnt_ff == count) begin
               state_in = ST_HEAD;
            end
         end

         ST_HEAD: begin
            next_wr  = '{en: 1'b1, addr: '0, data: ENTRY_W'(1)};
            prev_wr  = '{en: 1'b1, addr: '0, data: count};
            state_in = ST_IDLE;
         end

         ST_WALK: begin
            // Follow next links one entry a cycle, summing odd positions
            rd_addr = next_rdata;
            alu_req = '{op: ALU_ADD, a: sum_ff, b: SUM_W'(next_rdata)};
            if (cnt_ff[0]) begin
               sum_in = alu_res;
            end
            cnt_in = cnt_ff + ENTRY_W'(1);
            if (cnt_ff == count) begin
               state_in = ST_FIX;
            end
         end

         ST_FIX: begin
            alu_req = '{op: ALU_SUB, a: total_ff, b: sum_ff};
            if (flag_ff && !count[0]) begin
               sum_in = alu_res;
            end
            state_in = ST_OUT;
         end

         ST_OUT: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = sum_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      xa_ff       <= xa_in;
      xb_ff       <= xb_in;
      px_ff       <= px_in;
      nx_ff       <= nx_in;
      py_ff       <= py_in;
      ny_ff       <= ny_in;
      lag_ff      <= lag_in;
      sum_ff      <= sum_in;
      total_ff    <= total_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: hw/rtl/linked_list_reorder_engine_top.sv
// Top level of the linked list reorder engine.
// Keeps a circular doubly linked list of entries 0..n, entry 0 the head.
// Items come on the req_ channel (valid/stall): mode, entry_a, entry_b.
// Report items give one result on the rsp_ channel (valid/stall); no other
// mode gives a result. csr_ writes set entry_count (n), taken at once.
// One item at a time; req_stall stays high while an item is at work.
// Work per item, from the accept until req_stall drops:
//   reverse, bad entries, unused modes: req_stall never rises
//   move before/after: 2 link reads, 1 plan, 3 rejoins; a skipped move ends at the plan
//   swap: the same steps as a move, and an extra rejoin for entries that are not neighbors
//   init: one link pair written per cycle, then the head
//   report: one next link followed per cycle through the read port, then the fix and output
// The rate is set by the one write and one read port of each link memory.
// The result sits in an output register, so the next item is accepted
// while it waits; a report finishing while it still waits holds until
// rsp_stall drops. Reset clears the reversed flag, sets n to 1024 and
// empties the output; the links hold nothing until an init item.
`timescale 1ns / 1ps

module linked_list_reorder_engine_top
   import llre_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [MODE_W-1:0]  req_mode,
   input  logic [ENTRY_W-1:0] req_entry_a,
   input  logic [ENTRY_W-1:0] req_entry_b,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [SUM_W-1:0]   rsp_odd_position_sum,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [ENTRY_W-1:0] csr_entry_count
);

   logic [ENTRY_W-1:0] entry_count_ff, entry_count_in;
   logic [ENTRY_W-1:0] count;
   logic [ENTRY_W-1:0] rd_addr;
   logic [ENTRY_W-1:0] next_rdata, prev_rdata;
   ram_wr_type         next_wr, prev_wr;
   alu_req_type        alu_req;
   logic [SUM_W-1:0]   alu_res;

   // Entry count register, always ready
   assign csr_ready      = 1'b1;
   assign entry_count_in = (csr_valid && csr_ready) ? csr_entry_count : entry_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= ENTRY_W'(MAX_ENTRIES);
      end else begin
         entry_count_ff <= entry_count_in;
      end
   end

   // Clamp n into 1..MAX_ENTRIES
   always_comb begin
      count = entry_count_ff;
      if (entry_count_ff == '0) begin
         count = ENTRY_W'(1);
      end else if (entry_count_ff > ENTRY_W'(MAX_ENTRIES)) begin
         count = ENTRY_W'(MAX_ENTRIES);
      end
   end

   llre_seq u_seq (
      .clock                (clock),
      .reset                (reset),
      .count                (count),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_mode             (req_mode),
      .req_entry_a          (req_entry_a),
      .req_entry_b          (req_entry_b),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_odd_position_sum (rsp_odd_position_sum),
      .rd_addr              (rd_addr),
      .next_rdata           (next_rdata),
      .prev_rdata           (prev_rdata),
      .next_wr              (next_wr),
      .prev_wr              (prev_wr),
      .alu_req              (alu_req),
      .alu_res              (alu_res)
   );

   llre_alu u_alu (
      .alu_req (alu_req),
      .alu_res (alu_res)
   );

   // Next links
   llre_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (LINK_DEPTH)
   ) u_next_ram (
      .clock   (clock),
      .wr_en   (next_wr.en),
      .wr_addr (next_wr.addr),
      .wr_data (next_wr.data),
      .rd_addr (rd_addr),
      .rd_data (next_rdata)
   );

   // Previous links
   llre_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (LINK_DEPTH)
   ) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_wr.en),
      .wr_addr (prev_wr.addr),
      .wr_data (prev_wr.data),
      .rd_addr (rd_addr),
      .rd_data (prev_rdata)
   );

endmodule

// File: hw/rtl/llre_checker.sv
// Port-level checks of the reorder engine, bound to its top level.
`timescale 1ns / 1ps

module llre_checker
   import llre_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [MODE_W-1:0]  req_mode,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [SUM_W-1:0]   rsp_odd_position_sum
);

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_odd_position_sum))
      else $error("stalled result changed or vanished");

   // Init and report items keep the block busy
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_mode == MODE_INIT || req_mode == MODE_REPORT)
      |=> req_stall)
      else $error("block took a new item right after an init or report");

   // Reverse finishes in its accept cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_mode == MODE_REVERSE |=> !req_stall)
      else $error("reverse item kept the block busy");

   // A fresh result comes only out of a busy report
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared while the block was idle");

endmodule

bind linked_list_reorder_engine_top llre_checker u_checker (.*);

// File: verif/llre_order_checker.sv
// Watches the linked list reorder engine channels, predicts its report sums and compares them.
`timescale 1ns / 1ps

module llre_order_checker
   import llre_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [MODE_W-1:0]  req_mode,
   input  logic [ENTRY_W-1:0] req_entry_a,
   input  logic [ENTRY_W-1:0] req_entry_b,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [SUM_W-1:0]   rsp_odd_position_sum,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [ENTRY_W-1:0] csr_entry_count,
   output int                 mismatch_count,
   output int                 result_backlog
);

   // Mirror of the list: forward and backward links, reversed flag, entry count
   logic [ENTRY_W-1:0] link_next [0:MAX_ENTRIES];
   logic [ENTRY_W-1:0] link_prev [0:MAX_ENTRIES];
   logic               list_reversed;
   logic [ENTRY_W-1:0] live_count;

   // Report sums still owed by the block, oldest first
   logic [SUM_W-1:0]   expected_sums [$];
   logic [SUM_W-1:0]   wanted_sum;

   task automatic report_mismatch(input string what, input logic [SUM_W-1:0] seen,
                                  input logic [SUM_W-1:0] wanted);
      $display("%0t: %s, got %0d, want %0d", $time, what, seen, wanted);
      mismatch_count++;
   endtask

   // Join l to r in both directions
   task automatic link_pair(input logic [ENTRY_W-1:0] l, input logic [ENTRY_W-1:0] r);
      link_next[l] = r;
      link_prev[r] = l;
   endtask

   // Apply one accepted item to the mirror; a report queues its sum
   task automatic apply_list_item(input logic [MODE_W-1:0]  mode,
                                  input logic [ENTRY_W-1:0] entry_a,
                                  input logic [ENTRY_W-1:0] entry_b);
      int unsigned        n;
      logic [ENTRY_W-1:0] x, y, hold, lx, rx, ly, ry, cur;
      logic [MODE_W-1:0]  op;
      longint unsigned    odd_sum, full_sum;
      logic [SUM_W-1:0]   reported;
      if (live_count == 0) n = 1;
      else if (live_count > MAX_ENTRIES) n = MAX_ENTRIES;
      else n = 32'(live_count);
      x = entry_a;
      y = entry_b;
      op = mode;
      case (mode)
         MODE_INIT: begin
            for (int unsigned i = 1; i <= n; i++) begin
               link_prev[i] = ENTRY_W'(i - 1);
               link_next[i] = (i == n) ? '0 : ENTRY_W'(i + 1);
            end
            link_prev[0] = ENTRY_W'(n);
            link_next[0] = ENTRY_W'(1);
            list_reversed = 1'b0;
         end
         MODE_REVERSE: list_reversed = ~list_reversed;
         MODE_REPORT: begin
            odd_sum = 0;
            cur = '0;
            for (int unsigned i = 1; i <= n; i++) begin
               cur = link_next[cur];
               if (i % 2 == 1) odd_sum += 64'(cur);
            end
            // complement against the full sum when reversed with an even count
            if (list_reversed && (n % 2 == 0)) begin
               full_sum = 64'(n) * 64'(n + 1) / 2;
               odd_sum = full_sum - odd_sum;
            end
            reported = odd_sum[SUM_W-1:0];
            expected_sums.push_back(reported);
         end
         MODE_BEFORE, MODE_AFTER, MODE_SWAP: begin
            // drop items with out-of-range or equal entries
            if (x != 0 && y != 0 && x <= n && y <= n && x != y) begin
               // neighbors given in reverse order: exchange roles
               if (op == MODE_SWAP && link_next[y] == x) begin
                  hold = x;
                  x = y;
                  y = hold;
               end
               // reversed list: before and after trade places
               if (op != MODE_SWAP && list_reversed)
                  op = (op == MODE_BEFORE) ? MODE_AFTER : MODE_BEFORE;
               // skip moves that leave the order unchanged
               if (!((op == MODE_BEFORE && x == link_prev[y]) ||
                     (op == MODE_AFTER && x == link_next[y]))) begin
                  lx = link_prev[x];
                  rx = link_next[x];
                  ly = link_prev[y];
                  ry = link_next[y];
                  if (op == MODE_BEFORE) begin
                     link_pair(lx, rx);
                     link_pair(ly, x);
                     link_pair(x, y);
                  end else if (op == MODE_AFTER) begin
                     link_pair(lx, rx);
                     link_pair(x, ry);
                     link_pair(y, x);
                  end else if (rx == y) begin
                     link_pair(lx, y);
                     link_pair(y, x);
                     link_pair(x, ry);
                  end else begin
                     link_pair(lx, y);
                     link_pair(y, rx);
                     link_pair(ly, x);
                     link_pair(x, ry);
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   // Compare results, advance the mirror, then track register writes
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= MAX_ENTRIES; i++) begin
            link_next[i] = '0;
            link_prev[i] = '0;
         end
         list_reversed = 1'b0;
         live_count = ENTRY_W'(MAX_ENTRIES);
         expected_sums.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_sums.size() == 0) begin
               report_mismatch("odd_position_sum with no report pending",
                               rsp_odd_position_sum, '0);
            end else begin
               wanted_sum = expected_sums.pop_front();
               if (rsp_odd_position_sum !== wanted_sum)
                  report_mismatch("odd_position_sum mismatch", rsp_odd_position_sum,
                                  wanted_sum);
            end
         end
         // an item taken on the same edge as a write still sees the old count
         if (req_valid && !req_stall) apply_list_item(req_mode, req_entry_a, req_entry_b);
         if (csr_valid && csr_ready) live_count = csr_entry_count;
      end
      result_backlog <= expected_sums.size();
   end

endmodule

// File: verif/linked_list_reorder_engine_top_tb.sv
// Stimulus and verdict for the linked list reorder engine, with the checker beside it.
`timescale 1ns / 1ps

module linked_list_reorder_engine_top_tb;
   import llre_pkg::*;

   localparam int QUIET_LIMIT = 20000;
   localparam int HOLD_LEN    = 300;
   localparam int SETTLE_WAIT = MAX_ENTRIES + 16;
   localparam int PHASES      = 13;

   // Modes the block does not define
   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_style_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [MODE_W-1:0]  req_mode = MODE_INIT;
   logic [ENTRY_W-1:0] req_entry_a = '0;
   logic [ENTRY_W-1:0] req_entry_b = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [SUM_W-1:0]   rsp_odd_position_sum;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [ENTRY_W-1:0] csr_entry_count = '0;

   int                 mismatch_count;
   int                 result_backlog;
   int                 list_n = MAX_ENTRIES;
   int                 send_idle_pct = 0;
   int                 stall_pct = 0;
   int                 hold_left = 0;
   logic               hold_go = 1'b0;
   int                 quiet_cycles = 0;
   int                 count_plan [0:PHASES-1] = '{1, 0, 2, 3, 5, 8, 13, 2047, 16, 31,
                                                    1024, 64, 7};

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   linked_list_reorder_engine_top DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_mode             (req_mode),
      .req_entry_a          (req_entry_a),
      .req_entry_b          (req_entry_b),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_odd_position_sum (rsp_odd_position_sum),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_entry_count      (csr_entry_count)
   );

   llre_order_checker checker_inst (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_mode             (req_mode),
      .req_entry_a          (req_entry_a),
      .req_entry_b          (req_entry_b),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_odd_position_sum (rsp_odd_position_sum),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_entry_count      (csr_entry_count),
      .mismatch_count       (mismatch_count),
      .result_backlog       (result_backlog)
   );

   // Receiver: a long hold when asked, random stalls otherwise
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_go) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_LEN;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one item, hold it until taken, then idle at random
   task automatic send_item(input logic [MODE_W-1:0] mode, input logic [ENTRY_W-1:0] a,
                            input logic [ENTRY_W-1:0] b);
      req_valid <= 1'b1;
      req_mode <= mode;
      req_entry_a <= a;
      req_entry_b <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Stop offering and wait until every report sum has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (result_backlog != 0) @(posedge clock);
   endtask

   // Write entry_count once the block has gone idle
   task automatic write_entry_count(input logic [ENTRY_W-1:0] value);
      drain_results();
      repeat (SETTLE_WAIT) @(posedge clock);
      csr_valid <= 1'b1;
      csr_entry_count <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (value == 0) list_n = 1;
      else if (value > MAX_ENTRIES) list_n = MAX_ENTRIES;
      else list_n = int'(value);
   endtask

   task automatic set_idling(input idle_style_type style);
      case (style)
         IDLE_SENDER: begin
            send_idle_pct = 62;
            stall_pct <= 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            stall_pct <= 62;
         end
         IDLE_BOTH: begin
            send_idle_pct = 15;
            stall_pct <= 15;
         end
         default: begin
            send_idle_pct = 0;
            stall_pct <= 0;
         end
      endcase
   endtask

   // Mostly well-formed edits and reports on live entries, some noise
   task automatic send_random_item();
      int                 pick;
      logic [MODE_W-1:0]  mode;
      logic [ENTRY_W-1:0] a, b;
      pick = $urandom_range(0, 99);
      a = ENTRY_W'($urandom_range(1, list_n));
      b = ENTRY_W'($urandom_range(1, list_n));
      if (pick < 25) mode = MODE_BEFORE;
      else if (pick < 50) mode = MODE_AFTER;
      else if (pick < 70) mode = MODE_SWAP;
      else if (pick < 78) mode = MODE_REVERSE;
      else if (pick < 92) mode = MODE_REPORT;
      else if (pick < 95) mode = MODE_INIT;
      else begin
         mode = MODE_W'($urandom_range(0, 7));
         a = ENTRY_W'($urandom_range(0, 2047));
         b = ENTRY_W'($urandom_range(0, 2047));
      end
      send_item(mode, a, b);
   endtask

   initial begin
      int quota;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Before any init: only items that touch no link
      send_item(MODE_REVERSE, 11'd2047, 11'd0);
      send_item(MODE_SPARE_LO, 11'd2047, 11'd2047);
      send_item(MODE_SPARE_HI, 11'd0, 11'd0);
      send_item(MODE_BEFORE, 11'd0, 11'd5);
      send_item(MODE_AFTER, 11'd1025, 11'd3);
      send_item(MODE_SWAP, 11'd7, 11'd7);
      send_item(MODE_BEFORE, 11'd1, 11'd2047);

      // Full-size list at the reset count, plain and reversed
      send_item(MODE_INIT, 11'd1024, 11'd1024);
      send_item(MODE_REPORT, 11'd0, 11'd0);
      send_item(MODE_REVERSE, 11'd0, 11'd0);
      send_item(MODE_REPORT, 11'd0, 11'd0);

      // Short list: skipped moves, swaps of every shape, reversed moves
      write_entry_count(11'd6);
      send_item(MODE_INIT, 11'd0, 11'd0);
      send_item(MODE_BEFORE, 11'd3, 11'd4);
      send_item(MODE_AFTER, 11'd4, 11'd3);
      send_item(MODE_BEFORE, 11'd6, 11'd1);
      send_item(MODE_AFTER, 11'd1, 11'd5);
      send_item(MODE_REPORT, 11'd0, 11'd0);
      send_item(MODE_SWAP, 11'd2, 11'd3);
      send_item(MODE_SWAP, 11'd4, 11'd2);
      send_item(MODE_SWAP, 11'd6, 11'd1);
      send_item(MODE_REPORT, 11'd0, 11'd0);
      send_item(MODE_REVERSE, 11'd0, 11'd0);
      send_item(MODE_BEFORE, 11'd2, 11'd5);
      send_item(MODE_REPORT, 11'd0, 11'd0);
      send_item(MODE_AFTER, 11'd5, 11'd2);
      send_item(MODE_REPORT, 11'd0, 11'd0);

      // Random phases, each at its own count and idling style
      for (int p = 0; p < PHASES; p++) begin
         write_entry_count(ENTRY_W'(count_plan[p]));
         set_idling(idle_style_type'(p % 4));
         send_item(MODE_INIT, ENTRY_W'($urandom_range(0, 2047)),
                   ENTRY_W'($urandom_range(0, 2047)));
         quota = (list_n >= 64) ? 12 : 32;
         for (int k = 0; k < quota; k++) begin
            // hold the receiver off while reports pile up behind it
            if (p == 4 && k == 10) begin
               hold_go <= 1'b1;
               @(posedge clock);
               hold_go <= 1'b0;
               repeat (8) send_item(MODE_REPORT, 11'd0, 11'd0);
            end
            send_random_item();
         end
      end

      // Drain and let the block settle before the verdict
      set_idling(IDLE_NONE);
      drain_results();
      repeat (SETTLE_WAIT) @(posedge clock);
      if (mismatch_count == 0 && result_backlog == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
